[hdl/hpack_pkg.sv]
// Shared types, constants and the static Huffman code table for the HPACK encoder.
package hpack_pkg;

	localparam int unsigned SYM_W = 8;
	localparam int unsigned CODE_W = 30;
	localparam int unsigned LEN_W = 5;
	localparam int unsigned ENTRY_W = CODE_W + LEN_W;
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned ACC_W = 40;
	localparam int unsigned CNT_W = 6;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_req_t;

	function automatic logic [ENTRY_W-1:0] code_entry(input logic [SYM_W-1:0] sym);
		logic [CODE_W-1:0] c;
		logic [LEN_W-1:0]  l;
		c = '0;
		l = '0;
		unique case (sym)
			8'd0: begin c = 30'h1ff8; l = 5'd13; end
			8'd1: begin c = 30'h7fffd8; l = 5'd23; end
			8'd2: begin c = 30'hfffffe2; l = 5'd28; end
			8'd3: begin c = 30'hfffffe3; l = 5'd28; end
			8'd4: begin c = 30'hfffffe4; l = 5'd28; end
			8'd5: begin c = 30'hfffffe5; l = 5'd28; end
			8'd6: begin c = 30'hfffffe6; l = 5'd28; end
			8'd7: begin c = 30'hfffffe7; l = 5'd28; end
			8'd8: begin c = 30'hfffffe8; l = 5'd28; end
			8'd9: begin c = 30'hffffea; l = 5'd24; end
			8'd10: begin c = 30'h3ffffffc; l = 5'd30; end
			8'd11: begin c = 30'hfffffe9; l = 5'd28; end
			8'd12: begin c = 30'hfffffea; l = 5'd28; end
			8'd13: begin c = 30'h3ffffffd; l = 5'd30; end
			8'd14: begin c = 30'hfffffeb; l = 5'd28; end
			8'd15: begin c = 30'hfffffec; l = 5'd28; end
			8'd16: begin c = 30'hfffffed; l = 5'd28; end
			8'd17: begin c = 30'hfffffee; l = 5'd28; end
			8'd18: begin c = 30'hfffffef; l = 5'd28; end
			8'd19: begin c = 30'hffffff0; l = 5'd28; end
			8'd20: begin c = 30'hffffff1; l = 5'd28; end
			8'd21: begin c = 30'hffffff2; l = 5'd28; end
			8'd22: begin c = 30'h3ffffffe; l = 5'd30; end
			8'd23: begin c = 30'hffffff3; l = 5'd28; end
			8'd24: begin c = 30'hffffff4; l = 5'd28; end
			8'd25: begin c = 30'hffffff5; l = 5'd28; end
			8'd26: begin c = 30'hffffff6; l = 5'd28; end
			8'd27: begin c = 30'hffffff7; l = 5'd28; end
			8'd28: begin c = 30'hffffff8; l = 5'd28; end
			8'd29: begin c = 30'hffffff9; l = 5'd28; end
			8'd30: begin c = 30'hffffffa; l = 5'd28; end
			8'd31: begin c = 30'hffffffb; l = 5'd28; end
			8'd32: begin c = 30'h14; l = 5'd6; end
			8'd33: begin c = 30'h3f8; l = 5'd10; end
			8'd34: begin c = 30'h3f9; l = 5'd10; end
			8'd35: begin c = 30'hffa; l = 5'd12; end
			8'd36: begin c = 30'h1ff9; l = 5'd13; end
			8'd37: begin c = 30'h15; l = 5'd6; end
			8'd38: begin c = 30'hf8; l = 5'd8; end
			8'd39: begin c = 30'h7fa; l = 5'd11; end
			8'd40: begin c = 30'h3fa; l = 5'd10; end
			8'd41: begin c = 30'h3fb; l = 5'd10; end
			8'd42: begin c = 30'hf9; l = 5'd8; end
			8'd43: begin c = 30'h7fb; l = 5'd11; end
			8'd44: begin c = 30'hfa; l = 5'd8; end
			8'd45: begin c = 30'h16; l = 5'd6; end
			8'd46: begin c = 30'h17; l = 5'd6; end
			8'd47: begin c = 30'h18; l = 5'd6; end
			8'd48: begin c = 30'h0; l = 5'd5; end
			8'd49: begin c = 30'h1; l = 5'd5; end
			8'd50: begin c = 30'h2; l = 5'd5; end
			8'd51: begin c = 30'h19; l = 5'd6; end
			8'd52: begin c = 30'h1a; l = 5'd6; end
			8'd53: begin c = 30'h1b; l = 5'd6; end
			8'd54: begin c = 30'h1c; l = 5'd6; end
			8'd55: begin c = 30'h1d; l = 5'd6; end
			8'd56: begin c = 30'h1e; l = 5'd6; end
			8'd57: begin c = 30'h1f; l = 5'd6; end
			8'd58: begin c = 30'h5c; l = 5'd7; end
			8'd59: begin c = 30'hfb; l = 5'd8; end
			8'd60: begin c = 30'h7ffc; l = 5'd15; end
			8'd61: begin c = 30'h20; l = 5'd6; end
			8'd62: begin c = 30'hffb; l = 5'd12; end
			8'd63: begin c = 30'h3fc; l = 5'd10; end
			8'd64: begin c = 30'h1ffa; l = 5'd13; end
			8'd65: begin c = 30'h21; l = 5'd6; end
			8'd66: begin c = 30'h5d; l = 5'd7; end
			8'd67: begin c = 30'h5e; l = 5'd7; end
			8'd68: begin c = 30'h5f; l = 5'd7; end
			8'd69: begin c = 30'h60; l = 5'd7; end
			8'd70: begin c = 30'h61; l = 5'd7; end
			8'd71: begin c = 30'h62; l = 5'd7; end
			8'd72: begin c = 30'h63; l = 5'd7; end
			8'd73: begin c = 30'h64; l = 5'd7; end
			8'd74: begin c = 30'h65; l = 5'd7; end
			8'd75: begin c = 30'h66; l = 5'd7; end
			8'd76: begin c = 30'h67; l = 5'd7; end
			8'd77: begin c = 30'h68; l = 5'd7; end
			8'd78: begin c = 30'h69; l = 5'd7; end
			8'd79: begin c = 30'h6a; l = 5'd7; end
			8'd80: begin c = 30'h6b; l = 5'd7; end
			8'd81: begin c = 30'h6c; l = 5'd7; end
			8'd82: begin c = 30'h6d; l = 5'd7; end
			8'd83: begin c = 30'h6e; l = 5'd7; end
			8'd84: begin c = 30'h6f; l = 5'd7; end
			8'd85: begin c = 30'h70; l = 5'd7; end
			8'd86: begin c = 30'h71; l = 5'd7; end
			8'd87: begin c = 30'h72; l = 5'd7; end
			8'd88: begin c = 30'hfc; l = 5'd8; end
			8'd89: begin c = 30'h73; l = 5'd7; end
			8'd90: begin c = 30'hfd; l = 5'd8; end
			8'd91: begin c = 30'h1ffb; l = 5'd13; end
			8'd92: begin c = 30'h7fff0; l = 5'd19; end
			8'd93: begin c = 30'h1ffc; l = 5'd13; end
			8'd94: begin c = 30'h3ffc; l = 5'd14; end
			8'd95: begin c = 30'h22; l = 5'd6; end
			8'd96: begin c = 30'h7ffd; l = 5'd15; end
			8'd97: begin c = 30'h3; l = 5'd5; end
			8'd98: begin c = 30'h23; l = 5'd6; end
			8'd99: begin c = 30'h4; l = 5'd5; end
			8'd100: begin c = 30'h24; l = 5'd6; end
			8'd101: begin c = 30'h5; l = 5'd5; end
			8'd102: begin c = 30'h25; l = 5'd6; end
			8'd103: begin c = 30'h26; l = 5'd6; end
			8'd104: begin c = 30'h27; l = 5'd6; end
			8'd105: begin c = 30'h6; l = 5'd5; end
			8'd106: begin c = 30'h74; l = 5'd7; end
			8'd107: begin c = 30'h75; l = 5'd7; end
			8'd108: begin c = 30'h28; l = 5'd6; end
			8'd109: begin c = 30'h29; l = 5'd6; end
			8'd110: begin c = 30'h2a; l = 5'd6; end
			8'd111: begin c = 30'h7; l = 5'd5; end
			8'd112: begin c = 30'h2b; l = 5'd6; end
			8'd113: begin c = 30'h76; l = 5'd7; end
			8'd114: begin c = 30'h2c; l = 5'd6; end
			8'd115: begin c = 30'h8; l = 5'd5; end
			8'd116: begin c = 30'h9; l = 5'd5; end
			8'd117: begin c = 30'h2d; l = 5'd6; end
			8'd118: begin c = 30'h77; l = 5'd7; end
			8'd119: begin c = 30'h78; l = 5'd7; end
			8'd120: begin c = 30'h79; l = 5'd7; end
			8'd121: begin c = 30'h7a; l = 5'd7; end
			8'd122: begin c = 30'h7b; l = 5'd7; end
			8'd123: begin c = 30'h7ffe; l = 5'd15; end
			8'd124: begin c = 30'h7fc; l = 5'd11; end
			8'd125: begin c = 30'h3ffd; l = 5'd14; end
			8'd126: begin c = 30'h1ffd; l = 5'd13; end
			8'd127: begin c = 30'hffffffc; l = 5'd28; end
			8'd128: begin c = 30'hfffe6; l = 5'd20; end
			8'd129: begin c = 30'h3fffd2; l = 5'd22; end
			8'd130: begin c = 30'hfffe7; l = 5'd20; end
			8'd131: begin c = 30'hfffe8; l = 5'd20; end
			8'd132: begin c = 30'h3fffd3; l = 5'd22; end
			8'd133: begin c = 30'h3fffd4; l = 5'd22; end
			8'd134: begin c = 30'h3fffd5; l = 5'd22; end
			8'd135: begin c = 30'h7fffd9; l = 5'd23; end
			8'd136: begin c = 30'h3fffd6; l = 5'd22; end
			8'd137: begin c = 30'h7fffda; l = 5'd23; end
			8'd138: begin c = 30'h7fffdb; l = 5'd23; end
			8'd139: begin c = 30'h7fffdc; l = 5'd23; end
			8'd140: begin c = 30'h7fffdd; l = 5'd23; end
			8'd141: begin c = 30'h7fffde; l = 5'd23; end
			8'd142: begin c = 30'hffffeb; l = 5'd24; end
			8'd143: begin c = 30'h7fffdf; l = 5'd23; end
			8'd144: begin c = 30'hffffec; l = 5'd24; end
			8'd145: begin c = 30'hffffed; l = 5'd24; end
			8'd146: begin c = 30'h3fffd7; l = 5'd22; end
			8'd147: begin c = 30'h7fffe0; l = 5'd23; end
			8'd148: begin c = 30'hffffee; l = 5'd24; end
			8'd149: begin c = 30'h7fffe1; l = 5'd23; end
			8'd150: begin c = 30'h7fffe2; l = 5'd23; end
			8'd151: begin c = 30'h7fffe3; l = 5'd23; end
			8'd152: begin c = 30'h7fffe4; l = 5'd23; end
			8'd153: begin c = 30'h1fffdc; l = 5'd21; end
			8'd154: begin c = 30'h3fffd8; l = 5'd22; end
			8'd155: begin c = 30'h7fffe5; l = 5'd23; end
			8'd156: begin c = 30'h3fffd9; l = 5'd22; end
			8'd157: begin c = 30'h7fffe6; l = 5'd23; end
			8'd158: begin c = 30'h7fffe7; l = 5'd23; end
			8'd159: begin c = 30'hffffef; l = 5'd24; end
			8'd160: begin c = 30'h3fffda; l = 5'd22; end
			8'd161: begin c = 30'h1fffdd; l = 5'd21; end
			8'd162: begin c = 30'hfffe9; l = 5'd20; end
			8'd163: begin c = 30'h3fffdb; l = 5'd22; end
			8'd164: begin c = 30'h3fffdc; l = 5'd22; end
			8'd165: begin c = 30'h7fffe8; l = 5'd23; end
			8'd166: begin c = 30'h7fffe9; l = 5'd23; end
			8'd167: begin c = 30'h1fffde; l = 5'd21; end
			8'd168: begin c = 30'h7fffea; l = 5'd23; end
			8'd169: begin c = 30'h3fffdd; l = 5'd22; end
			8'd170: begin c = 30'h3fffde; l = 5'd22; end
			8'd171: begin c = 30'hfffff0; l = 5'd24; end
			8'd172: begin c = 30'h1fffdf; l = 5'd21; end
			8'd173: begin c = 30'h3fffdf; l = 5'd22; end
			8'd174: begin c = 30'h7fffeb; l = 5'd23; end
			8'd175: begin c = 30'h7fffec; l = 5'd23; end
			8'd176: begin c = 30'h1fffe0; l = 5'd21; end
			8'd177: begin c = 30'h1fffe1; l = 5'd21; end
			8'd178: begin c = 30'h3fffe0; l = 5'd22; end
			8'd179: begin c = 30'h1fffe2; l = 5'd21; end
			8'd180: begin c = 30'h7fffed; l = 5'd23; end
			8'd181: begin c = 30'h3fffe1; l = 5'd22; end
			8'd182: begin c = 30'h7fffee; l = 5'd23; end
			8'd183: begin c = 30'h7fffef; l = 5'd23; end
			8'd184: begin c = 30'hfffea; l = 5'd20; end
			8'd185: begin c = 30'h3fffe2; l = 5'd22; end
			8'd186: begin c = 30'h3fffe3; l = 5'd22; end
			8'd187: begin c = 30'h3fffe4; l = 5'd22; end
			8'd188: begin c = 30'h7ffff0; l = 5'd23; end
			8'd189: begin c = 30'h3fffe5; l = 5'd22; end
			8'd190: begin c = 30'h3fffe6; l = 5'd22; end
			8'd191: begin c = 30'h7ffff1; l = 5'd23; end
			8'd192: begin c = 30'h3ffffe0; l = 5'd26; end
			8'd193: begin c = 30'h3ffffe1; l = 5'd26; end
			8'd194: begin c = 30'hfffeb; l = 5'd20; end
			8'd195: begin c = 30'h7fff1; l = 5'd19; end
			8'd196: begin c = 30'h3fffe7; l = 5'd22; end
			8'd197: begin c = 30'h7ffff2; l = 5'd23; end
			8'd198: begin c = 30'h3fffe8; l = 5'd22; end
			8'd199: begin c = 30'h1ffffec; l = 5'd25; end
			8'd200: begin c = 30'h3ffffe2; l = 5'd26; end
			8'd201: begin c = 30'h3ffffe3; l = 5'd26; end
			8'd202: begin c = 30'h3ffffe4; l = 5'd26; end
			8'd203: begin c = 30'h7ffffde; l = 5'd27; end
			8'd204: begin c = 30'h7ffffdf; l = 5'd27; end
			8'd205: begin c = 30'h3ffffe5; l = 5'd26; end
			8'd206: begin c = 30'hfffff1; l = 5'd24; end
			8'd207: begin c = 30'h1ffffed; l = 5'd25; end
			8'd208: begin c = 30'h7fff2; l = 5'd19; end
			8'd209: begin c = 30'h1fffe3; l = 5'd21; end
			8'd210: begin c = 30'h3ffffe6; l = 5'd26; end
			8'd211: begin c = 30'h7ffffe0; l = 5'd27; end
			8'd212: begin c = 30'h7ffffe1; l = 5'd27; end
			8'd213: begin c = 30'h3ffffe7; l = 5'd26; end
			8'd214: begin c = 30'h7ffffe2; l = 5'd27; end
			8'd215: begin c = 30'hfffff2; l = 5'd24; end
			8'd216: begin c = 30'h1fffe4; l = 5'd21; end
			8'd217: begin c = 30'h1fffe5; l = 5'd21; end
			8'd218: begin c = 30'h3ffffe8; l = 5'd26; end
			8'd219: begin c = 30'h3ffffe9; l = 5'd26; end
			8'd220: begin c = 30'hffffffd; l = 5'd28; end
			8'd221: begin c = 30'h7ffffe3; l = 5'd27; end
			8'd222: begin c = 30'h7ffffe4; l = 5'd27; end
			8'd223: begin c = 30'h7ffffe5; l = 5'd27; end
			8'd224: begin c = 30'hfffec; l = 5'd20; end
			8'd225: begin c = 30'hfffff3; l = 5'd24; end
			8'd226: begin c = 30'hfffed; l = 5'd20; end
			8'd227: begin c = 30'h1fffe6; l = 5'd21; end
			8'd228: begin c = 30'h3fffe9; l = 5'd22; end
			8'd229: begin c = 30'h1fffe7; l = 5'd21; end
			8'd230: begin c = 30'h1fffe8; l = 5'd21; end
			8'd231: begin c = 30'h7ffff3; l = 5'd23; end
			8'd232: begin c = 30'h3fffea; l = 5'd22; end
			8'd233: begin c = 30'h3fffeb; l = 5'd22; end
			8'd234: begin c = 30'h1ffffee; l = 5'd25; end
			8'd235: begin c = 30'h1ffffef; l = 5'd25; end
			8'd236: begin c = 30'hfffff4; l = 5'd24; end
			8'd237: begin c = 30'hfffff5; l = 5'd24; end
			8'd238: begin c = 30'h3ffffea; l = 5'd26; end
			8'd239: begin c = 30'h7ffff4; l = 5'd23; end
			8'd240: begin c = 30'h3ffffeb; l = 5'd26; end
			8'd241: begin c = 30'h7ffffe6; l = 5'd27; end
			8'd242: begin c = 30'h3ffffec; l = 5'd26; end
			8'd243: begin c = 30'h3ffffed; l = 5'd26; end
			8'd244: begin c = 30'h7ffffe7; l = 5'd27; end
			8'd245: begin c = 30'h7ffffe8; l = 5'd27; end
			8'd246: begin c = 30'h7ffffe9; l = 5'd27; end
			8'd247: begin c = 30'h7ffffea; l = 5'd27; end
			8'd248: begin c = 30'h7ffffeb; l = 5'd27; end
			8'd249: begin c = 30'hffffffe; l = 5'd28; end
			8'd250: begin c = 30'h7ffffec; l = 5'd27; end
			8'd251: begin c = 30'h7ffffed; l = 5'd27; end
			8'd252: begin c = 30'h7ffffee; l = 5'd27; end
			8'd253: begin c = 30'h7ffffef; l = 5'd27; end
			8'd254: begin c = 30'h7fffff0; l = 5'd27; end
			8'd255: begin c = 30'h3ffffee; l = 5'd26; end
		endcase
		return {c, l};
	endfunction

endpackage

[hdl/hpack_code_rom.sv]
// Static Huffman code ROM with a registered read port.
module hpack_code_rom #(
	parameter int unsigned WIDTH = hpack_pkg::ENTRY_W,
	parameter int unsigned DEPTH = hpack_pkg::TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [WIDTH-1:0]         rdata
);

	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= WIDTH'(hpack_pkg::code_entry(hpack_pkg::SYM_W'(addr)));
		end
	end

endmodule

[hdl/hpack_huffman_encoder.sv]
// Top level of the HPACK static Huffman encoder: code lookup, bit packer and output register.
// A symbol's first byte passes the ROM lookup register, the packer accumulator and the
// output register before it is offered. The packer loads one code, then drains up to five
// bytes, one per cycle while the output is free, before it takes the next code.
// The code ROM has one registered read port, which forms the lookup stage.
// Reset clears the accumulator, pending count and all valid flags.
module hpack_huffman_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hpack_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hpack_pkg::out_req_t out_data
);

	localparam int unsigned AW = hpack_pkg::ACC_W;
	localparam int unsigned CW = hpack_pkg::CNT_W;

	logic                         v_s1;
	logic                         last_s1;
	logic [hpack_pkg::ENTRY_W-1:0] rom_q;
	logic [hpack_pkg::CODE_W-1:0]  code;
	logic [hpack_pkg::LEN_W-1:0]   len;

	logic          busy_q;
	logic          flush_q;
	logic [AW-1:0] acc_q;
	logic [CW-1:0] cnt_q;

	logic          out_v_q;
	hpack_pkg::out_req_t out_q;

	logic          out_free;
	logic          load;
	logic          emit;
	logic [AW-1:0] acc_app;
	logic [CW-1:0] cnt_app;
	logic [2:0]    pad;
	logic [CW-1:0] cnt_emit;
	logic [AW-1:0] acc_shift;

	assign out_free = !out_v_q || out_ready;
	assign {code, len} = rom_q;

	// The packer takes a new code only once the previous one has fully drained.
	assign load = v_s1 && !busy_q;
	assign in_ready = !v_s1 || load;

	hpack_code_rom #(
		.WIDTH(hpack_pkg::ENTRY_W),
		.DEPTH(hpack_pkg::TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.en   (in_ready),
		.addr (in_data.symbol),
		.rdata(rom_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			last_s1 <= in_data.last_symbol;
		end
	end

	always_comb begin
		acc_app = (acc_q << len) | AW'(code);
		cnt_app = cnt_q + CW'(len);
		pad = 3'd0;
		if (last_s1) begin
			pad = 3'(4'd8 - {1'b0, cnt_app[2:0]});
		end
		acc_shift = (acc_app << pad) | AW'((8'd1 << pad) - 8'd1);
	end

	assign emit = busy_q && (cnt_q >= CW'(8)) && out_free;
	assign cnt_emit = cnt_q - CW'(8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				busy_q  <= 1'b1;
				flush_q <= last_s1;
				acc_q   <= acc_shift;
				cnt_q   <= cnt_app + CW'(pad);
			end else if (busy_q) begin
				if (cnt_q < CW'(8)) begin
					busy_q <= 1'b0;
				end else if (emit) begin
					cnt_q <= cnt_emit;
					if (cnt_emit < CW'(8)) begin
						busy_q <= 1'b0;
						if (flush_q) begin
							acc_q <= '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte  <= 8'(acc_q >> cnt_emit);
			out_q.last_byte <= flush_q && (cnt_emit < CW'(8));
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q < CW'(8))
		else $error("pending count not below a byte while idle");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && flush_q && cnt_emit < CW'(8)) |=> cnt_q == '0)
		else $error("flush left pending bits");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |=> !$past(emit))
		else $error("emit overwrote a stalled result");
`endif

endmodule
